/* hw/rtl/rmps_pkg.sv */
package rmps_pkg;

    localparam int COLS    = 8;
    localparam int ROWS    = 8;
    localparam int CH_W    = 8;
    localparam int PIX_W   = 3 * CH_W;
    localparam int WORD_W  = ROWS * PIX_W;
    localparam int COL_W   = $clog2(COLS);
    localparam int ROW_W   = $clog2(ROWS);
    localparam int TONE_W  = 16;

    // PWM steps per column before the scan moves on
    localparam int LEVELS  = 15;

    // aux byte goes out on a tick when brightness + column hits one of these
    localparam int AUX_STEP_A = 0;
    localparam int AUX_STEP_B = 4;

    localparam int ADDR_W  = 3;
    localparam logic [0:0] REG_AUX_LEDS = 1'b0;

    typedef enum logic [2:0] {
        OP_TICK  = 3'd0,
        OP_WRITE = 3'd1,
        OP_READ  = 3'd2,
        OP_CLEAR = 3'd3,
        OP_TONE  = 3'd4
    } op_t;

    typedef struct packed {
        logic [2:0]        opcode;
        logic [COL_W-1:0]  pixel_x;
        logic [ROW_W-1:0]  pixel_y;
        logic [CH_W-1:0]   red_value;
        logic [CH_W-1:0]   green_value;
        logic [CH_W-1:0]   blue_value;
        logic [TONE_W-1:0] tone_period;
        logic [TONE_W-1:0] tone_duration;
    } rmps_item_t;

    typedef struct packed {
        logic [CH_W-1:0]   aux_byte;
        logic [ROWS-1:0]   red_row;
        logic [ROWS-1:0]   green_row;
        logic [ROWS-1:0]   blue_row;
        logic [COL_W-1:0]  active_column;
        logic              sound_on;
        logic [TONE_W-1:0] current_tone;
        logic [CH_W-1:0]   read_red;
        logic [CH_W-1:0]   read_green;
        logic [CH_W-1:0]   read_blue;
    } rmps_result_t;

    // transaction in flight between the scan control and the row output stage
    typedef struct packed {
        logic [2:0]        op;
        logic [ROW_W-1:0]  row;
        logic [CH_W-1:0]   bright;
        logic [COL_W-1:0]  column;
        logic              sound;
        logic [TONE_W-1:0] tone;
        logic [CH_W-1:0]   aux;
        logic [ROWS-1:0]   lane_valid;
    } rmps_stage_t;

endpackage

/* hw/rtl/rmps_frame_mem.sv */
module rmps_frame_mem (
    input  logic                           clk,
    input  logic                           we,
    input  logic [rmps_pkg::COL_W-1:0]     waddr,
    input  logic [rmps_pkg::ROW_W-1:0]     wlane,
    input  logic [rmps_pkg::PIX_W-1:0]     wdata,
    input  logic                           re,
    input  logic [rmps_pkg::COL_W-1:0]     raddr,
    output logic [rmps_pkg::WORD_W-1:0]    rdata
);
    import rmps_pkg::*;

    // one word per column, one 24-bit lane per row
    logic [WORD_W-1:0] mem [COLS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr][wlane * PIX_W +: PIX_W] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* hw/rtl/rmps_scan_ctrl.sv */
module rmps_scan_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  rmps_pkg::rmps_item_t          item,
    input  logic [rmps_pkg::CH_W-1:0]     aux_leds,
    input  logic                          out_ready,
    output logic                          stage_valid,
    output rmps_pkg::rmps_stage_t         stage,
    output logic                          mem_we,
    output logic                          mem_re,
    output logic [rmps_pkg::COL_W-1:0]    mem_raddr
);
    import rmps_pkg::*;

    logic [CH_W-1:0]            bright_reg, bright_next;
    logic [COL_W-1:0]           column_reg, column_next;
    logic [TONE_W-1:0]          remain_reg, remain_next;
    logic                       sound_reg, sound_next;
    logic [TONE_W-1:0]          tone_reg, tone_next;
    logic [COLS-1:0][ROWS-1:0]  valid_reg, valid_next;
    logic                       stage_valid_reg, stage_valid_next;
    rmps_stage_t                stage_reg, stage_next;

    logic                       accept;
    logic [CH_W:0]              bright_inc;
    logic [CH_W:0]              aux_sum;
    logic                       aux_hit;
    logic [COL_W-1:0]           rd_col;

    assign item_stall = stage_valid_reg && !out_ready;
    assign accept     = item_valid && !item_stall;

    always_comb
    begin
        bright_next = bright_reg;
        column_next = column_reg;
        remain_next = remain_reg;
        sound_next  = sound_reg;
        tone_next   = tone_reg;
        valid_next  = valid_reg;
        bright_inc  = {1'b0, bright_reg} + (CH_W + 1)'(1);
        mem_we      = 1'b0;

        if (accept)
        begin
            unique case (item.opcode)
                OP_TICK:
                begin
                    if (bright_inc >= (CH_W + 1)'(LEVELS))
                    begin
                        bright_next = '0;
                        column_next = column_reg + COL_W'(1);
                        if (remain_reg != '0)
                        begin
                            remain_next = remain_reg - TONE_W'(1);
                            if (remain_reg == TONE_W'(1))
                            begin
                                sound_next = 1'b0;
                            end
                        end
                    end
                    else
                    begin
                        bright_next = bright_inc[CH_W-1:0];
                    end
                end
                OP_WRITE:
                begin
                    valid_next[item.pixel_x][item.pixel_y] = 1'b1;
                    mem_we = 1'b1;
                end
                OP_CLEAR:
                begin
                    valid_next = '0;
                end
                OP_TONE:
                begin
                    tone_next   = item.tone_period;
                    sound_next  = 1'b1;
                    remain_next = item.tone_duration;
                end
                default:
                begin
                end
            endcase
        end
    end

    // aux test uses the values after the advance
    assign aux_sum = {1'b0, bright_next} + (CH_W + 1)'(column_next);
    assign aux_hit = (aux_sum == (CH_W + 1)'(AUX_STEP_A))
                  || (aux_sum == (CH_W + 1)'(AUX_STEP_B));

    assign rd_col    = (item.opcode == OP_TICK) ? column_next : item.pixel_x;
    assign mem_re    = accept;
    assign mem_raddr = rd_col;

    always_comb
    begin
        stage_next            = stage_reg;
        stage_valid_next      = stage_valid_reg;
        if (accept)
        begin
            stage_valid_next      = 1'b1;
            stage_next.op         = item.opcode;
            stage_next.row        = item.pixel_y;
            stage_next.bright     = bright_next;
            stage_next.column     = column_next;
            stage_next.sound      = sound_next;
            stage_next.tone       = tone_next;
            stage_next.aux        = (item.opcode == OP_TICK && aux_hit) ? aux_leds : '0;
            stage_next.lane_valid = valid_reg[rd_col];
        end
        else if (out_ready)
        begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bright_reg      <= '0;
            column_reg      <= '0;
            remain_reg      <= '0;
            sound_reg       <= 1'b0;
            tone_reg        <= '0;
            valid_reg       <= '0;
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            bright_reg      <= bright_next;
            column_reg      <= column_next;
            remain_reg      <= remain_next;
            sound_reg       <= sound_next;
            tone_reg        <= tone_next;
            valid_reg       <= valid_next;
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_reg <= stage_next;
    end

    assign stage_valid = stage_valid_reg;
    assign stage       = stage_reg;

    // PWM counter never reaches the wrap value
    a_bright_range: assert property (@(posedge clk) disable iff (!rst_n)
        bright_reg < CH_W'(LEVELS))
        else $error("brightness counter out of range");

    // a clear leaves no pixel valid
    a_clear_all: assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.opcode == OP_CLEAR |=> valid_reg == '0)
        else $error("frame clear left valid pixels");

    // stall only while the stage holds an undelivered transaction
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> stage_valid_reg)
        else $error("input stalled with empty stage");

    // a transaction held in the stage is not dropped
    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid_reg && !out_ready |=> stage_valid_reg && $stable(stage_reg))
        else $error("stalled stage transaction lost");

endmodule

/* hw/rtl/rmps_row_out.sv */
module rmps_row_out (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          stage_valid,
    input  rmps_pkg::rmps_stage_t         stage,
    input  logic [rmps_pkg::WORD_W-1:0]   rdata,
    output logic                          out_ready,
    output logic                          result_valid,
    input  logic                          result_stall,
    output rmps_pkg::rmps_result_t        result
);
    import rmps_pkg::*;

    logic                       valid_reg, valid_next;
    rmps_result_t               result_reg, result_next;
    logic [ROWS-1:0][PIX_W-1:0] lanes;
    logic [ROWS-1:0]            red_on, green_on, blue_on;
    logic [PIX_W-1:0]           pick;

    assign out_ready = !valid_reg || !result_stall;

    // never-written pixels read as zero
    always_comb
    begin
        for (int r = 0; r < ROWS; r++)
        begin
            lanes[r]    = stage.lane_valid[r] ? rdata[r * PIX_W +: PIX_W] : '0;
            red_on[r]   = lanes[r][3*CH_W-1:2*CH_W] > stage.bright;
            green_on[r] = lanes[r][2*CH_W-1:CH_W]   > stage.bright;
            blue_on[r]  = lanes[r][CH_W-1:0]        > stage.bright;
        end
    end

    assign pick = lanes[stage.row];

    always_comb
    begin
        result_next               = '0;
        result_next.aux_byte      = stage.aux;
        result_next.active_column = stage.column;
        result_next.sound_on      = stage.sound;
        result_next.current_tone  = stage.tone;
        if (stage.op == OP_TICK)
        begin
            result_next.red_row   = red_on;
            result_next.green_row = green_on;
            result_next.blue_row  = blue_on;
        end
        if (stage.op == OP_READ)
        begin
            result_next.read_red   = pick[3*CH_W-1:2*CH_W];
            result_next.read_green = pick[2*CH_W-1:CH_W];
            result_next.read_blue  = pick[CH_W-1:0];
        end
    end

    assign valid_next = out_ready ? stage_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && stage_valid)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = valid_reg;
    assign result       = result_reg;

endmodule

/* hw/rtl/rgb_matrix_pwm_scan.sv */
// Channel   Direction  Handshake                       Payload
// item      in         item_valid / item_stall         rmps_item_t
// result    out        result_valid / result_stall     rmps_result_t
// config    in         APB (psel/penable/pwrite/pready) aux_leds at byte address 0
//
// One transaction per cycle sustained while result_stall is low; each result
// passes the stage register, which holds the state update and column-word read
// of the frame memory, then the PWM compares or readback into the result register.
// Reset clears the counters, tone state and all 64 pixel valid bits at once,
// so the frame reads as black right away (no clearing pass).
// A stalled result holds; the stage behind it fills, then item_stall rises.
module rgb_matrix_pwm_scan (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 item_valid,
    output logic                                 item_stall,
    input  rmps_pkg::rmps_item_t                 item,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output rmps_pkg::rmps_result_t               result,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [rmps_pkg::ADDR_W-1:0]          paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);
    import rmps_pkg::*;

    logic [CH_W-1:0]    aux_leds_reg;
    logic               out_ready;
    logic               stage_valid;
    rmps_stage_t        stage;
    logic               mem_we;
    logic               mem_re;
    logic [COL_W-1:0]   mem_raddr;
    logic [WORD_W-1:0]  mem_rdata;
    logic               reg_sel;

    // ------------------------------------------------------------------
    // Config register: one byte, word index taken from paddr[2]
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == REG_AUX_LEDS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            aux_leds_reg <= '0;
        end
        else if (psel && penable && pwrite && pready && reg_sel)
        begin
            aux_leds_reg <= pwdata[CH_W-1:0];
        end
    end

    assign prdata = reg_sel ? {{(32 - CH_W){1'b0}}, aux_leds_reg} : '0;

    // ------------------------------------------------------------------
    // Scan control: PWM/column/tone state, pixel valid bits, memory
    // addressing and the stage register ahead of the compares
    // ------------------------------------------------------------------
    rmps_scan_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .item        (item),
        .aux_leds    (aux_leds_reg),
        .out_ready   (out_ready),
        .stage_valid (stage_valid),
        .stage       (stage),
        .mem_we      (mem_we),
        .mem_re      (mem_re),
        .mem_raddr   (mem_raddr)
    );

    // ------------------------------------------------------------------
    // Frame memory: 8 column words of 8 x 24-bit pixels; a write touches
    // one lane, a read returns the whole column for the tick compares
    // ------------------------------------------------------------------
    rmps_frame_mem u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (item.pixel_x),
        .wlane (item.pixel_y),
        .wdata ({item.red_value, item.green_value, item.blue_value}),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // ------------------------------------------------------------------
    // Row output: 24 brightness compares or pixel readback, into the
    // result register
    // ------------------------------------------------------------------
    rmps_row_out u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .stage_valid  (stage_valid),
        .stage        (stage),
        .rdata        (mem_rdata),
        .out_ready    (out_ready),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
